@@ rtl/core/sound_peak_window_meter_top_assert.svh @@
// Assertion macros for the sound peak window meter checker.
// Plain concurrent-assertion wrappers; expect clk and arst_n in scope.
`ifndef SOUND_PEAK_WINDOW_METER_TOP_ASSERT_SVH
`define SOUND_PEAK_WINDOW_METER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define SWM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sound peak window meter: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define SWM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sound peak window meter: next-cycle check failed");

`endif

@@ rtl/core/swm_pkg.sv @@
// Shared widths, codes, types and conversion functions of the sound peak window meter.
// No dependencies; imported by every module of the block.
package swm_pkg;

	localparam int SAMPLE_W = 12;
	localparam int TICK_W   = 10;
	localparam int DB_W     = 10;
	localparam int LUX_W    = 14;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 40;

	localparam logic [SAMPLE_W-1:0] SAMPLE_LIMIT = 12'd4095;
	localparam logic [TICK_W-1:0]   WINDOW_RESET = 10'd50;
	localparam logic [DB_W-1:0]     DB_TENTHS_LOW  = 10'd400;
	localparam logic [DB_W-1:0]     DB_TENTHS_HIGH = 10'd1000;

	// Register index, taken from paddr[2]
	localparam logic REG_WINDOW_TICKS = 1'b0;

	// Item kind on the input tuser
	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

	// Window close event handed from the tracker to the result stage
	typedef struct packed {
		logic                valid;
		logic                empty;
		logic [SAMPLE_W-1:0] p2p;
		logic [SAMPLE_W-1:0] light;
	} win_close_t;

	// Level in tenths of a dB: (4500 + 9*p2p + 5) / 10, clamped to 400..1000.
	// From p2p = 612 up the level is always above the ceiling.
	function automatic logic [DB_W-1:0] tenths_of(input logic [SAMPLE_W-1:0] p2p);
		logic [13:0]   y;
		logic [29:0]   prod;
		logic [DB_W-1:0] t;
		y    = 14'd4505 + 14'(p2p[9:0]) * 14'd9;
		// divide by ten: multiply by 52429 / 2^19, exact for y below 43690
		prod = 30'(y) * 30'd52429;
		t    = prod[28:19];
		if (p2p >= 12'd612) begin
			tenths_of = DB_TENTHS_HIGH;
		end else if (t < DB_TENTHS_LOW) begin
			tenths_of = DB_TENTHS_LOW;
		end else if (t > DB_TENTHS_HIGH) begin
			tenths_of = DB_TENTHS_HIGH;
		end else begin
			tenths_of = t;
		end
	endfunction

	// Lux: floor(raw * 10000 / 4095). The estimate never overshoots and is at most
	// one short, so a single remainder compare fixes it.
	function automatic logic [LUX_W-1:0] lux_of(input logic [SAMPLE_W-1:0] raw);
		logic [25:0]      x;
		logic [25:0]      sum;
		logic [LUX_W-1:0] q0;
		logic [25:0]      back;
		logic [25:0]      rem;
		x    = 26'(raw) * 26'd10000;
		sum  = x + (x >> 12) + (x >> 24);
		q0   = sum[25:12];
		back = {q0, 12'b0} - 26'(q0);
		rem  = x - back;
		lux_of = (rem >= 26'd4095) ? q0 + 14'd1 : q0;
	endfunction

endpackage

@@ rtl/core/swm_cfg.sv @@
// APB register file of the sound peak window meter: the window length register.
// Depends on swm_pkg.
module swm_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [swm_pkg::APB_AW-1:0]  paddr,
	input  logic [swm_pkg::APB_DW-1:0]  pwdata,
	output logic [swm_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output logic [swm_pkg::TICK_W-1:0]  window_ticks
);
	import swm_pkg::*;

	logic [TICK_W-1:0] window_q;
	logic              wr_en;
	logic              sel_window;

	assign pready     = 1'b1;
	assign sel_window = (paddr[2] == REG_WINDOW_TICKS);
	assign wr_en      = psel & penable & pwrite & pready & sel_window;

	// window length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (wr_en) begin
			window_q <= pwdata[TICK_W-1:0];
		end
	end

	assign prdata       = sel_window ? APB_DW'(window_q) : '0;
	assign window_ticks = window_q;

endmodule

@@ rtl/core/swm_track.sv @@
// Input register and window trackers (max, min, tick count) of the sound peak window meter.
// Depends on swm_pkg; raises a close event on the tick that ends a window.
module swm_track (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [swm_pkg::S_DATA_W-1:0]  s_axis_tdata,
	input  logic                          s_axis_tuser,
	input  logic [swm_pkg::TICK_W-1:0]    window_ticks,
	input  logic                          out_free,
	output swm_pkg::win_close_t           close_ev
);
	import swm_pkg::*;

	logic                valid_s1;
	logic                func_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [SAMPLE_W-1:0] light_s1;

	logic [SAMPLE_W-1:0] max_q;
	logic [SAMPLE_W-1:0] min_q;
	logic [TICK_W-1:0]   tick_q;

	logic [TICK_W-1:0]   tick_next;
	logic                closing;
	logic                fire;
	logic                take;

	// window closes when the advanced count reaches the length
	assign tick_next = tick_q + 1'b1;
	assign closing   = (func_s1 == FUNC_TICK) && !(tick_next < window_ticks);
	assign fire      = valid_s1 && (!closing || out_free);
	assign s_axis_tready = !valid_s1 || fire;
	assign take      = s_axis_tvalid && s_axis_tready;

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (take) begin
			func_s1   <= s_axis_tuser;
			sample_s1 <= s_axis_tdata[SAMPLE_W-1:0];
			light_s1  <= s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
		end
	end

	// trackers: samples of full scale are ignored, a closing tick restarts the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q  <= '0;
			min_q  <= SAMPLE_LIMIT;
			tick_q <= '0;
		end else if (fire) begin
			if (func_s1 == FUNC_SAMPLE) begin
				if (sample_s1 < SAMPLE_LIMIT) begin
					if (sample_s1 > max_q) max_q <= sample_s1;
					if (sample_s1 < min_q) min_q <= sample_s1;
				end
			end else if (closing) begin
				max_q  <= '0;
				min_q  <= SAMPLE_LIMIT;
				tick_q <= '0;
			end else begin
				tick_q <= tick_next;
			end
		end
	end

	// close event; empty when no sample got in, which leaves min above max
	always_comb begin
		close_ev.valid = fire && closing;
		close_ev.empty = (min_q > max_q);
		close_ev.p2p   = close_ev.empty ? '0 : max_q - min_q;
		close_ev.light = light_s1;
	end

endmodule

@@ rtl/core/swm_calc.sv @@
// Result conversion and output register of the sound peak window meter.
// Depends on swm_pkg (tenths_of, lux_of).
module swm_calc (
	input  logic                          clk,
	input  logic                          arst_n,
	input  swm_pkg::win_close_t           close_ev,
	output logic                          out_free,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [swm_pkg::M_DATA_W-1:0]  m_axis_tdata,
	output logic                          m_axis_tuser
);
	import swm_pkg::*;

	logic                m_valid_q;
	logic [SAMPLE_W-1:0] p2p_q;
	logic [DB_W-1:0]     db_q;
	logic [LUX_W-1:0]    lux_q;
	logic                empty_q;

	assign out_free = !m_valid_q || m_axis_tready;

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= close_ev.valid;
		end
	end

	// output payload, converted on the way in
	always_ff @(posedge clk) begin
		if (close_ev.valid) begin
			p2p_q   <= close_ev.p2p;
			db_q    <= tenths_of(close_ev.p2p);
			lux_q   <= lux_of(close_ev.light);
			empty_q <= close_ev.empty;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {4'b0, lux_q, db_q, p2p_q};
	assign m_axis_tuser  = empty_q;

endmodule

@@ rtl/core/sound_peak_window_meter_top.sv @@
// Channel   | dir | beat contents
// s_axis    | in  | tdata: noise_sample[11:0], light_raw[23:12]; tuser: func (1 = tick)
// m_axis    | out | tdata: peak_to_peak[11:0], decibel_tenths[21:12], lux[35:22]
//           |     |        (zero fill to 40 bits); tuser: empty_window
// apb       | in  | window_ticks at byte address 0, bits [9:0]
// One beat is taken every cycle unless a closing tick is held; the input register and
// the tracker update form one stage. A closing tick passes the input register, then the
// output register loads its window result. Only a closing tick waits on a full output
// register; samples and other ticks pass regardless. Reset restores a window of 50 ticks
// and empty trackers.
// Top level of the sound peak window meter; depends on swm_pkg, swm_cfg, swm_track, swm_calc.
module sound_peak_window_meter_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// noise_sample [11:0], light_raw [23:12]
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [swm_pkg::S_DATA_W-1:0]  s_axis_tdata,
	// func [0]
	input  logic [0:0]                    s_axis_tuser,
	// peak_to_peak [11:0], decibel_tenths [21:12], lux [35:22], zeros [39:36]
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [swm_pkg::M_DATA_W-1:0]  m_axis_tdata,
	// empty_window [0]
	output logic [0:0]                    m_axis_tuser,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [swm_pkg::APB_AW-1:0]    paddr,
	input  logic [swm_pkg::APB_DW-1:0]    pwdata,
	output logic [swm_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);
	import swm_pkg::*;

	logic [TICK_W-1:0] window_ticks;
	logic              out_free;
	win_close_t        close_ev;

	swm_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.window_ticks (window_ticks)
	);

	swm_track u_track (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser[0]),
		.window_ticks  (window_ticks),
		.out_free      (out_free),
		.close_ev      (close_ev)
	);

	swm_calc u_calc (
		.clk           (clk),
		.arst_n        (arst_n),
		.close_ev      (close_ev),
		.out_free      (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser[0])
	);

endmodule

@@ rtl/core/swm_checker.sv @@
// Port-level checker of the sound peak window meter, bound to the top level.
// Depends on swm_pkg and the assertion macros header.
`include "sound_peak_window_meter_top_assert.svh"

module swm_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	input  logic [swm_pkg::M_DATA_W-1:0]  m_axis_tdata,
	input  logic [0:0]                    m_axis_tuser
);
	import swm_pkg::*;

	// a stalled result beat holds
	`SWM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// an empty window reports zero span and the level of zero span
	`SWM_ASSERT_NOW(a_empty_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[11:0] == 12'd0 && m_axis_tdata[21:12] == 10'd450)

	// level stays inside the clamp range
	`SWM_ASSERT_NOW(a_db_range, m_axis_tvalid, m_axis_tdata[21:12] >= DB_TENTHS_LOW && m_axis_tdata[21:12] <= DB_TENTHS_HIGH)

	// lux never exceeds full scale and the fill bits stay clear
	`SWM_ASSERT_NOW(a_lux_range, m_axis_tvalid, m_axis_tdata[35:22] <= 14'd10000 && m_axis_tdata[39:36] == 4'd0)

endmodule

bind sound_peak_window_meter_top swm_checker u_swm_checker (.*);

@@ bench/testbench.sv @@
// Testbench for the sound peak window meter: streams samples and ticks, checks each window
// result against a cycle-free predictor held in a small scoreboard class.
// Depends on swm_pkg and sound_peak_window_meter_top.
module testbench;
	import swm_pkg::*;

	localparam int CLK_HALF = 6;
	localparam int LIMIT_CYCLES = 600000;
	localparam int SETTLE_CYCLES = 6;
	localparam int LONG_HOLD = 300;
	localparam int PHASES = 10;
	// window length, item count and share of ticks for each random phase
	localparam int PHASE_WIN [PHASES] = '{1, 0, 3, 1000, 2, 1023, 4, 7, 1, 5};
	localparam int PHASE_ITEMS [PHASES] = '{120, 80, 180, 60, 100, 60, 160, 200, 90, 200};
	localparam int PHASE_TICK_PCT [PHASES] = '{60, 40, 35, 50, 35, 50, 35, 30, 45, 35};

	typedef struct {
		logic [SAMPLE_W-1:0] p2p;
		logic [DB_W-1:0]     level;
		logic [LUX_W-1:0]    lux;
		logic                empty;
	} window_result_t;

	// Predicts window results and matches them against the output beats
	class window_scoreboard;
		window_result_t      due[$];
		logic [TICK_W-1:0]   win_len;
		logic [SAMPLE_W-1:0] hi_seen;
		logic [SAMPLE_W-1:0] lo_seen;
		logic [TICK_W-1:0]   ticks;
		int                  fails;

		function new();
			win_len = WINDOW_RESET;
			fails = 0;
			clear_trackers();
		endfunction

		function void clear_trackers();
			hi_seen = '0;
			lo_seen = SAMPLE_LIMIT;
			ticks = '0;
		endfunction

		function void set_window(input logic [TICK_W-1:0] len);
			win_len = len;
		endfunction

		function int pending();
			return due.size();
		endfunction

		// Input beat taken: update trackers, queue a result if this tick closes the window
		function void note_beat(input logic f, input logic [SAMPLE_W-1:0] ns,
				input logic [SAMPLE_W-1:0] lr);
			window_result_t r;
			int hundredths;
			int tenths;
			if (f == FUNC_SAMPLE) begin
				if (ns < SAMPLE_LIMIT) begin
					if (ns > hi_seen) hi_seen = ns;
					if (ns < lo_seen) lo_seen = ns;
				end
				return;
			end
			ticks = ticks + 1'b1;
			if (ticks < win_len) return;
			r.empty = lo_seen > hi_seen;
			r.p2p = r.empty ? '0 : hi_seen - lo_seen;
			hundredths = 4500 + 9 * int'(r.p2p);
			tenths = (hundredths + 5) / 10;
			if (tenths < int'(DB_TENTHS_LOW)) tenths = int'(DB_TENTHS_LOW);
			if (tenths > int'(DB_TENTHS_HIGH)) tenths = int'(DB_TENTHS_HIGH);
			r.level = tenths[DB_W-1:0];
			r.lux = LUX_W'((int'(lr) * 10000) / 4095);
			due.push_back(r);
			clear_trackers();
		endfunction

		function void report_field(input string name, input int want, input int got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
				fails++;
			end
		endfunction

		// Output beat taken: compare with the oldest outstanding window
		function void check_result(input logic [M_DATA_W-1:0] data, input logic [0:0] user);
			window_result_t r;
			if (due.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, got tdata %h tuser %b",
					$time, data, user);
				fails++;
				return;
			end
			r = due.pop_front();
			report_field("peak_to_peak", int'(r.p2p), int'(data[11:0]));
			report_field("decibel_tenths", int'(r.level), int'(data[21:12]));
			report_field("lux", int'(r.lux), int'(data[35:22]));
			report_field("tdata padding", 0, int'(data[M_DATA_W-1:36]));
			report_field("empty_window", int'(r.empty), int'(user[0]));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_DATA_W-1:0]   s_axis_tdata = '0;
	logic [0:0]            s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_axis_tdata;
	logic [0:0]            m_axis_tuser;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_AW-1:0]     paddr = '0;
	logic [APB_DW-1:0]     pwdata = '0;
	logic [APB_DW-1:0]     prdata;
	logic                  pready;

	window_scoreboard sb = new();
	bit sink_hold_long = 1'b0;
	bit sender_eager = 1'b0;

	always #CLK_HALF clk = ~clk;

	sound_peak_window_meter_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	function automatic int draw_gap(input bit eager);
		return eager ? 0 : $urandom_range(0, 19);
	endfunction

	// Sample values lean towards the extremes and the ignored full-scale code
	function automatic logic [SAMPLE_W-1:0] draw_sample();
		case ($urandom_range(0, 9))
			0: return SAMPLE_LIMIT;
			1: return '0;
			2: return SAMPLE_LIMIT - 1'b1;
			default: return SAMPLE_W'($urandom_range(0, 4095));
		endcase
	endfunction

	// One input beat, after a random gap; tvalid stays high when the gap is zero
	task automatic send_beat(input logic f, input logic [SAMPLE_W-1:0] ns,
			input logic [SAMPLE_W-1:0] lr);
		int gap;
		gap = draw_gap(sender_eager);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {lr, ns};
		s_axis_tuser <= f;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_beat(f, ns, lr);
		@(negedge clk);
	endtask

	// Stop sending and wait until every window result has come out
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() > 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// APB read of the window register, compared with the expected length
	task automatic check_window(input logic [TICK_W-1:0] want);
		psel <= 1'b1;
		pwrite <= 1'b0;
		penable <= 1'b0;
		paddr <= {REG_WINDOW_TICKS, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[TICK_W-1:0] !== want) begin
			$display("%0t: window_ticks readback mismatch, expected %0d, got %0d",
				$time, want, prdata[TICK_W-1:0]);
			sb.fails++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		// return to idle before the next transfer
		@(negedge clk);
	endtask

	// APB write of the window register; upper data bits carry noise
	task automatic set_window(input int len);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {REG_WINDOW_TICKS, 2'b00};
		pwdata <= (APB_DW'($urandom) & ~APB_DW'(10'h3FF)) | APB_DW'(len);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// return to idle before the readback
		@(negedge clk);
		sb.set_window(TICK_W'(len));
		check_window(TICK_W'(len));
	endtask

	// Result sink: random stalls, eager streaks, and one long hold on request
	initial begin : result_sink
		int gap;
		int streak;
		bit eager;
		streak = 0;
		eager = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (streak == 0) begin
				streak = $urandom_range(10, 40);
				eager = ($urandom_range(0, 2) == 0);
			end
			streak--;
			if (sink_hold_long) begin
				sink_hold_long = 1'b0;
				gap = LONG_HOLD;
			end else begin
				gap = draw_gap(eager);
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			sb.check_result(m_axis_tdata, m_axis_tuser);
			@(negedge clk);
		end
	end

	// Main sequence: reset, directed windows, then random phases
	initial begin : stimulus
		logic f;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		check_window(WINDOW_RESET);

		// directed: two-tick windows over the corner cases
		set_window(2);
		// window with no samples at all, dark light reading
		send_beat(FUNC_TICK, 12'd0, 12'd0);
		send_beat(FUNC_TICK, 12'd0, 12'd0);
		// full range swing, level pinned at the ceiling, full light
		send_beat(FUNC_SAMPLE, 12'd0, 12'd0);
		send_beat(FUNC_SAMPLE, 12'd4094, 12'hFFF);
		send_beat(FUNC_TICK, 12'd0, 12'd0);
		send_beat(FUNC_TICK, 12'd0, 12'd4095);
		// only a full-scale sample, and noise on a tick: still an empty window
		send_beat(FUNC_SAMPLE, 12'd4095, 12'd0);
		send_beat(FUNC_TICK, 12'd123, 12'd0);
		send_beat(FUNC_TICK, 12'hFFF, 12'd1);
		// single sample: zero swing but not empty
		send_beat(FUNC_SAMPLE, 12'd2000, 12'd0);
		send_beat(FUNC_TICK, 12'd0, 12'd0);
		send_beat(FUNC_TICK, 12'd0, 12'd2048);
		// half a tenth rounds up
		send_beat(FUNC_SAMPLE, 12'd100, 12'd0);
		send_beat(FUNC_SAMPLE, 12'd105, 12'd0);
		send_beat(FUNC_TICK, 12'd0, 12'd0);
		send_beat(FUNC_TICK, 12'd0, 12'd1234);
		// just under the ceiling
		send_beat(FUNC_SAMPLE, 12'd1000, 12'd0);
		send_beat(FUNC_SAMPLE, 12'd1610, 12'd0);
		send_beat(FUNC_TICK, 12'd0, 12'd0);
		send_beat(FUNC_TICK, 12'd0, 12'd4094);
		// first swing that reaches the ceiling
		send_beat(FUNC_SAMPLE, 12'd7, 12'd0);
		send_beat(FUNC_SAMPLE, 12'd618, 12'd0);
		send_beat(FUNC_TICK, 12'd0, 12'd0);
		send_beat(FUNC_TICK, 12'd0, 12'd2730);
		settle();

		// random phases; a phase that leaves a long window half full is followed by a
		// shorter one, so the next tick closes it
		for (int ph = 0; ph < PHASES; ph++) begin
			set_window(PHASE_WIN[ph]);
			sender_eager = ($urandom_range(0, 2) == 0);
			if (ph == 0) begin
				// hold the sink off while ticks keep coming, so the input backs up
				sink_hold_long = 1'b1;
				sender_eager = 1'b1;
			end
			for (int i = 0; i < PHASE_ITEMS[ph]; i++) begin
				f = ($urandom_range(0, 99) < PHASE_TICK_PCT[ph]) ? FUNC_TICK : FUNC_SAMPLE;
				send_beat(f, draw_sample(), draw_sample());
			end
			settle();
		end

		if (sb.fails == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Watchdog
	initial begin : watchdog
		#(2 * CLK_HALF * LIMIT_CYCLES);
		$display("status: fail");
		$finish;
	end

endmodule
